[rtl/core/gyro_bias_calibrator_defines.svh]
// assertion macros for the gyro bias calibrator
`ifndef GYRO_BIAS_CALIBRATOR_DEFINES_SVH
`define GYRO_BIAS_CALIBRATOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GBC_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("gyro bias calibrator check failed");

// next-cycle implication
`define GBC_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("gyro bias calibrator check failed");

`else

`define GBC_ASSERT_IMPLIES(label, clk, rst, lhs, rhs)
`define GBC_ASSERT_NEXT(label, clk, rst, lhs, rhs)

`endif

`endif

[rtl/core/gbc_pkg.sv]
`timescale 1ns / 1ps
package gbc_pkg;

  localparam int WARMUP_SAMPLES = 200;
  localparam int MEAN_SAMPLES   = 800;
  localparam int CHECK_SAMPLES  = 200;

  localparam int AXES     = 3;
  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 12;
  localparam int SQ_W     = 2 * SAMPLE_W;
  localparam int DEV_W    = 40;

  localparam logic [DEV_W-1:0] LIMIT_RESET = 40'd5877551;

  // running floor quotient and remainder of the axis sum by the mean count
  localparam int SAMPLE_SPAN = 2 ** (SAMPLE_W - 1);
  localparam int KOFF        = (SAMPLE_SPAN + MEAN_SAMPLES - 1) / MEAN_SAMPLES;
  localparam int OFF         = KOFF * MEAN_SAMPLES;
  localparam int U_MAX       = OFF + MEAN_SAMPLES - 1 + SAMPLE_SPAN - 1;
  localparam int U_W         = $clog2(U_MAX + 1);
  localparam int REM_W       = $clog2(MEAN_SAMPLES + 1);
  localparam int RECIP_W     = U_W + 1;
  localparam int QX_W        = RECIP_W + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << U_W) / MEAN_SAMPLES);

  localparam logic ACT_RESTART = 1'b0;
  localparam logic ACT_SAMPLE  = 1'b1;

  typedef enum logic [3:0] {
    PH_WARMUP = 4'b0001,
    PH_MEAN   = 4'b0010,
    PH_CHECK  = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic clear;
    logic mean;
    logic check;
    logic last;
  } op_t;

endpackage

[rtl/core/gyro_bias_calibrator.sv]
`timescale 1ns / 1ps
// Zero-rate bias calibration for a three-axis gyro.
// Input channel (in_valid / in_stall): action 0 restarts a run, action 1
// carries one sample_x/y/z request, one per cycle while in_stall is low.
// A run skips the warm-up samples, averages the mean samples per axis and
// sums squared deviations over the check samples. The last check sample
// yields one result request on out_valid / out_stall: accepted, the offsets
// now in use and the worst deviation sum.
// The offsets are replaced only when that sum is within the limit.
// Config channel (cfg_valid / cfg_ready, cfg_data) writes the 40-bit limit;
// cfg_ready is always high, write only while the block is idle.
// The result passes the register stages input, deviation square,
// accumulate, worst-of-three and result.
// Reset (rst, synchronous) empties the pipeline, restarts at warm-up,
// zeroes the kept offsets and loads the default limit.
// A held result does not block input until a second result is ready to
// leave; only then in_stall rises and the pipeline holds until out_stall
// drops.
module gyro_bias_calibrator
  import gbc_pkg::*;
(
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                action,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0] sample_x,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0] sample_y,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0] sample_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                accepted,
  output logic signed [gbc_pkg::SAMPLE_W-1:0] offset_x,
  output logic signed [gbc_pkg::SAMPLE_W-1:0] offset_y,
  output logic signed [gbc_pkg::SAMPLE_W-1:0] offset_z,
  output logic [gbc_pkg::DEV_W-1:0]           worst_variance_sum,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gbc_pkg::DEV_W-1:0]           cfg_data
);
`include "gyro_bias_calibrator_defines.svh"

  logic                       frozen;
  logic                       advance;
  logic [DEV_W-1:0]           limit;

  logic                       r0_valid;
  logic                       r0_action;
  logic signed [SAMPLE_W-1:0] r0_smp [AXES];
  logic signed [SAMPLE_W-1:0] r1_smp [AXES];
  logic signed [SAMPLE_W-1:0] in_smp [AXES];

  op_t                        op_now;
  op_t                        op1;
  op_t                        op2;
  logic                       ev3;
  logic                       ev4;

  logic signed [SAMPLE_W-1:0] cand_now [AXES];
  logic signed [SAMPLE_W-1:0] cand2 [AXES];
  logic signed [SAMPLE_W-1:0] cand3 [AXES];
  logic signed [SAMPLE_W-1:0] cand4 [AXES];
  logic signed [SAMPLE_W-1:0] kept [AXES];
  logic signed [SAMPLE_W-1:0] offs [AXES];

  logic [DEV_W-1:0]           dev [AXES];
  logic [DEV_W-1:0]           max01;
  logic [DEV_W-1:0]           worst_now;
  logic [DEV_W-1:0]           worst4;
  logic                       pass;
  logic                       load_out;

  assign frozen    = ev4 && out_valid && out_stall;
  assign advance   = !frozen;
  assign in_stall  = frozen;
  assign cfg_ready = 1'b1;

  assign in_smp[0] = sample_x;
  assign in_smp[1] = sample_y;
  assign in_smp[2] = sample_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      r0_valid <= 1'b0;
    end else if (advance) begin
      r0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      r0_action <= action;
      r0_smp    <= in_smp;
    end
  end

  gbc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .item_valid (r0_valid),
    .action     (r0_action),
    .op         (op_now)
  );

  // control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      op1 <= '0;
      op2 <= '0;
      ev3 <= 1'b0;
      ev4 <= 1'b0;
    end else if (advance) begin
      op1 <= op_now;
      op2 <= op1;
      ev3 <= op2.check && op2.last;
      ev4 <= ev3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      r1_smp <= r0_smp;
      cand2  <= cand_now;
      cand3  <= cand2;
      cand4  <= cand3;
      worst4 <= worst_now;
    end
  end

  for (genvar i = 0; i < AXES; i++) begin : g_axis
    gbc_mean_axis u_mean (
      .clk        (clk),
      .rst        (rst),
      .step_mean  (advance && op_now.mean),
      .step_clear (advance && op_now.clear),
      .sample     (r0_smp[i]),
      .cand       (cand_now[i])
    );

    gbc_dev_axis u_dev (
      .clk    (clk),
      .rst    (rst),
      .step   (advance),
      .op1    (op1),
      .op2    (op2),
      .sample (r1_smp[i]),
      .cand   (cand_now[i]),
      .dev    (dev[i])
    );
  end

  assign max01     = (dev[1] > dev[0]) ? dev[1] : dev[0];
  assign worst_now = (dev[2] > max01) ? dev[2] : max01;

  // result stage
  assign pass     = worst4 <= limit;
  assign load_out = ev4 && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        kept[i] <= '0;
      end
    end else if (load_out && pass) begin
      kept <= cand4;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      accepted           <= pass;
      worst_variance_sum <= worst4;
      offs               <= pass ? cand4 : kept;
    end
  end

  assign offset_x = offs[0];
  assign offset_y = offs[1];
  assign offset_z = offs[2];

  `GBC_ASSERT_IMPLIES(a_stall_cause, clk, rst, in_stall, out_valid && out_stall && ev4)
  `GBC_ASSERT_IMPLIES(a_op_exclusive, clk, rst, op1.clear || op1.mean || op1.check, $onehot({op1.clear, op1.mean, op1.check}))
  `GBC_ASSERT_IMPLIES(a_last_is_check, clk, rst, op1.last, op1.check)
  `GBC_ASSERT_NEXT(a_result_loaded, clk, rst, ev4 && !in_stall, out_valid)

endmodule

[rtl/core/gbc_ctrl.sv]
`timescale 1ns / 1ps
module gbc_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic         item_valid,
  input  logic         action,
  output gbc_pkg::op_t op
);
  import gbc_pkg::*;

  phase_t           phase;
  phase_t           phase_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W:0]   count_inc;
  logic             mean_now;

  assign count_inc = {1'b0, count} + (CNT_W+1)'(1);

  always_comb begin
    op         = '0;
    phase_next = phase;
    count_next = count;
    mean_now   = 1'b0;
    if (item_valid) begin
      if (action == ACT_RESTART) begin
        op.clear   = 1'b1;
        phase_next = PH_WARMUP;
        count_next = '0;
      end else begin
        unique case (phase)
          PH_WARMUP: begin
            if (count < CNT_W'(WARMUP_SAMPLES)) begin
              count_next = count_inc[CNT_W-1:0];
              if (count_inc >= (CNT_W+1)'(WARMUP_SAMPLES)) begin
                phase_next = PH_MEAN;
                count_next = '0;
              end
            end else begin
              mean_now = 1'b1;
            end
          end
          PH_MEAN: begin
            mean_now = 1'b1;
          end
          PH_CHECK: begin
            op.check = 1'b1;
            if (count_inc >= (CNT_W+1)'(CHECK_SAMPLES)) begin
              op.last    = 1'b1;
              phase_next = PH_DONE;
              count_next = '0;
            end else begin
              count_next = count_inc[CNT_W-1:0];
            end
          end
          PH_DONE: begin
          end
          default: begin
            phase_next = PH_WARMUP;
          end
        endcase
        if (mean_now) begin
          op.mean = 1'b1;
          if (count_inc >= (CNT_W+1)'(MEAN_SAMPLES)) begin
            phase_next = PH_CHECK;
            count_next = '0;
          end else begin
            count_next = count_inc[CNT_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WARMUP;
      count <= '0;
    end else if (step) begin
      phase <= phase_next;
      count <= count_next;
    end
  end

endmodule

[rtl/core/gbc_mean_axis.sv]
`timescale 1ns / 1ps
module gbc_mean_axis (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step_mean,
  input  logic                                step_clear,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0] sample,
  output logic signed [gbc_pkg::SAMPLE_W-1:0] cand
);
  import gbc_pkg::*;

  logic signed [SAMPLE_W-1:0]  quot;
  logic signed [SAMPLE_W-1:0]  quot_next;
  logic [REM_W-1:0]            rem;
  logic [REM_W-1:0]            rem_next;
  logic signed [U_W:0]         rem_ext;
  logic signed [U_W:0]         smp_ext;
  logic signed [U_W:0]         u_full;
  logic [U_W-1:0]              u;
  logic [U_W-1:0]              back;
  logic [U_W-1:0]              r_raw;
  logic [U_W+RECIP_W-1:0]      prod;
  logic [RECIP_W-1:0]          q_est;
  logic [RECIP_W-1:0]          q_u;
  logic                        fix;
  logic signed [QX_W-1:0]      q_sum;
  logic                        round_up;

  // offset keeps the shifted partial sum non-negative
  assign rem_ext = $signed((U_W+1)'(rem));
  assign smp_ext = (U_W+1)'(sample);
  assign u_full  = rem_ext + smp_ext + (U_W+1)'(OFF);
  assign u       = u_full[U_W-1:0];

  // reciprocal estimate, at most one low
  assign prod  = (U_W+RECIP_W)'(u) * (U_W+RECIP_W)'(RECIP);
  assign q_est = prod[U_W +: RECIP_W];
  assign back  = U_W'(q_est * RECIP_W'(MEAN_SAMPLES));
  assign r_raw = u - back;
  assign fix   = r_raw >= U_W'(MEAN_SAMPLES);
  assign q_u   = q_est + RECIP_W'(fix);

  assign rem_next  = fix ? REM_W'(r_raw - U_W'(MEAN_SAMPLES)) : REM_W'(r_raw);
  assign q_sum     = QX_W'(quot) + $signed(QX_W'(q_u)) - QX_W'(KOFF);
  assign quot_next = q_sum[SAMPLE_W-1:0];

  // floor to truncation toward zero
  assign round_up = quot[SAMPLE_W-1] && (rem != '0);
  assign cand     = quot + $signed({{(SAMPLE_W-1){1'b0}}, round_up});

  always_ff @(posedge clk) begin
    if (rst || step_clear) begin
      quot <= '0;
      rem  <= '0;
    end else if (step_mean) begin
      quot <= quot_next;
      rem  <= rem_next;
    end
  end

endmodule

[rtl/core/gbc_dev_axis.sv]
`timescale 1ns / 1ps
module gbc_dev_axis (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  gbc_pkg::op_t                        op1,
  input  gbc_pkg::op_t                        op2,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0] cand,
  output logic [gbc_pkg::DEV_W-1:0]           dev
);
  import gbc_pkg::*;

  logic signed [SAMPLE_W:0]     diff;
  logic signed [2*SAMPLE_W+1:0] sq_full;
  logic [SQ_W-1:0]              sq;
  logic [DEV_W:0]               acc;

  assign diff    = (SAMPLE_W+1)'(sample) - (SAMPLE_W+1)'(cand);
  assign sq_full = diff * diff;
  assign acc     = {1'b0, dev} + (DEV_W+1)'(sq);

  always_ff @(posedge clk) begin
    if (step && op1.check) begin
      sq <= sq_full[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dev <= '0;
    end else if (step) begin
      if (op2.clear) begin
        dev <= '0;
      end else if (op2.check) begin
        dev <= acc[DEV_W] ? '1 : acc[DEV_W-1:0];
      end
    end
  end

endmodule

[test/gbc_calibration_checker.sv]
`timescale 1ns / 1ps
module gbc_calibration_checker
  import gbc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       action,
  input  logic signed [SAMPLE_W-1:0] sample_x,
  input  logic signed [SAMPLE_W-1:0] sample_y,
  input  logic signed [SAMPLE_W-1:0] sample_z,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       accepted,
  input  logic signed [SAMPLE_W-1:0] offset_x,
  input  logic signed [SAMPLE_W-1:0] offset_y,
  input  logic signed [SAMPLE_W-1:0] offset_z,
  input  logic [DEV_W-1:0]           worst_variance_sum,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [DEV_W-1:0]           cfg_data,
  output int                         fail_count,
  output int                         results_waiting,
  output int                         results_predicted
);

  localparam int SUM_W = 26;

  typedef struct packed {
    logic                       accepted;
    logic signed [SAMPLE_W-1:0] offset_x;
    logic signed [SAMPLE_W-1:0] offset_y;
    logic signed [SAMPLE_W-1:0] offset_z;
    logic [DEV_W-1:0]           worst;
  } calib_result_t;

  calib_result_t              calib_results_q[$];
  calib_result_t              want_result;
  phase_t                     run_phase;
  int                         run_count;
  logic signed [SUM_W-1:0]    axis_total [AXES];
  logic signed [SAMPLE_W-1:0] candidate [AXES];
  logic [DEV_W-1:0]           dev_total [AXES];
  logic signed [SAMPLE_W-1:0] kept [AXES];
  logic [DEV_W-1:0]           var_limit;

  task automatic clear_run();
    run_phase = PH_WARMUP;
    run_count = 0;
    for (int a = 0; a < AXES; a++) begin
      axis_total[a] = '0;
      candidate[a]  = '0;
      dev_total[a]  = '0;
    end
  endtask

  task automatic predict_calibration(input logic act, input logic signed [SAMPLE_W-1:0] sx,
                                     input logic signed [SAMPLE_W-1:0] sy,
                                     input logic signed [SAMPLE_W-1:0] sz);
    logic signed [SAMPLE_W-1:0] smp [AXES];
    longint                     dev;
    logic [DEV_W:0]             acc;
    calib_result_t              res;
    smp = '{sx, sy, sz};
    if (act == ACT_RESTART) begin
      clear_run();
      return;
    end
    if (run_phase == PH_WARMUP) begin
      if (run_count < WARMUP_SAMPLES) begin
        run_count++;
        if (run_count >= WARMUP_SAMPLES) begin
          run_phase = PH_MEAN;
          run_count = 0;
        end
        return;
      end
      run_phase = PH_MEAN;
      run_count = 0;
    end
    if (run_phase == PH_MEAN) begin
      for (int a = 0; a < AXES; a++) axis_total[a] += smp[a];
      run_count++;
      if (run_count >= MEAN_SAMPLES) begin
        // signed division truncates toward zero
        for (int a = 0; a < AXES; a++) candidate[a] = SAMPLE_W'(axis_total[a] / MEAN_SAMPLES);
        run_phase = PH_CHECK;
        run_count = 0;
      end
      return;
    end
    if (run_phase != PH_CHECK) return;
    for (int a = 0; a < AXES; a++) begin
      dev = longint'(smp[a]) - longint'(candidate[a]);
      acc = {1'b0, dev_total[a]} + (DEV_W + 1)'(dev * dev);
      dev_total[a] = acc[DEV_W] ? '1 : acc[DEV_W-1:0];
    end
    run_count++;
    if (run_count < CHECK_SAMPLES) return;
    res.worst = dev_total[0];
    if (dev_total[1] > res.worst) res.worst = dev_total[1];
    if (dev_total[2] > res.worst) res.worst = dev_total[2];
    res.accepted = (res.worst <= var_limit);
    if (res.accepted) kept = candidate;
    res.offset_x = kept[0];
    res.offset_y = kept[1];
    res.offset_z = kept[2];
    run_phase = PH_DONE;
    run_count = 0;
    calib_results_q.push_back(res);
    results_predicted++;
  endtask

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_run();
      for (int a = 0; a < AXES; a++) kept[a] = '0;
      var_limit = LIMIT_RESET;
      calib_results_q.delete();
      fail_count = 0;
      results_predicted = 0;
    end else begin
      if (cfg_valid && cfg_ready) var_limit = cfg_data;
      if (in_valid && !in_stall) predict_calibration(action, sample_x, sample_y, sample_z);
      if (out_valid && !out_stall) begin
        if (calib_results_q.size() == 0) begin
          fail_count++;
          $display("%0t: result request expected none, got accepted %0b worst %0d",
                   $time, accepted, worst_variance_sum);
        end else begin
          want_result = calib_results_q.pop_front();
          check_field("accepted", want_result.accepted, accepted);
          check_field("offset_x", want_result.offset_x, offset_x);
          check_field("offset_y", want_result.offset_y, offset_y);
          check_field("offset_z", want_result.offset_z, offset_z);
          check_field("worst_variance_sum", want_result.worst, worst_variance_sum);
        end
      end
    end
    results_waiting = calib_results_q.size();
  end

endmodule

[test/tb_gyro_bias_calibrator.sv]
`timescale 1ns / 1ps
module tb_gyro_bias_calibrator;
  import gbc_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int HOLD_CYCLES     = 4000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int IDLE_PCT        = 22;
  localparam int MIN_RESULTS     = 36;
  localparam int MIN_REQUESTS    = 1150;
  localparam int RUN_SAMPLES     = WARMUP_SAMPLES + MEAN_SAMPLES + CHECK_SAMPLES;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

  typedef enum {RUN_STILL, RUN_QUIET, RUN_NOISY, RUN_WILD, RUN_SPAN} run_kind_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       action    = ACT_RESTART;
  logic signed [SAMPLE_W-1:0] sample_x  = '0;
  logic signed [SAMPLE_W-1:0] sample_y  = '0;
  logic signed [SAMPLE_W-1:0] sample_z  = '0;
  logic                       out_stall = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic [DEV_W-1:0]           cfg_data  = '0;

  logic                       in_stall;
  logic                       out_valid;
  logic                       accepted;
  logic signed [SAMPLE_W-1:0] offset_x;
  logic signed [SAMPLE_W-1:0] offset_y;
  logic signed [SAMPLE_W-1:0] offset_z;
  logic [DEV_W-1:0]           worst_variance_sum;
  logic                       cfg_ready;

  int fail_count;
  int results_waiting;
  int results_predicted;
  bit idle_en       = 1'b1;
  int hold_asked    = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int requests_sent = 0;
  int quiet_cycles  = 0;

  always #10 clk = ~clk;

  gyro_bias_calibrator i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .action             (action),
    .sample_x           (sample_x),
    .sample_y           (sample_y),
    .sample_z           (sample_z),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .accepted           (accepted),
    .offset_x           (offset_x),
    .offset_y           (offset_y),
    .offset_z           (offset_z),
    .worst_variance_sum (worst_variance_sum),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  gbc_calibration_checker i_checker (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .action             (action),
    .sample_x           (sample_x),
    .sample_y           (sample_y),
    .sample_z           (sample_z),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .accepted           (accepted),
    .offset_x           (offset_x),
    .offset_y           (offset_y),
    .offset_z           (offset_z),
    .worst_variance_sum (worst_variance_sum),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .results_waiting    (results_waiting),
    .results_predicted  (results_predicted)
  );

  // result receiver: random stalls, long hold-off on demand
  always @(negedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served = hold_served + 1;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_CYCLES) begin
      $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_CYCLES);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(input logic act, input logic signed [SAMPLE_W-1:0] sx,
                          input logic signed [SAMPLE_W-1:0] sy,
                          input logic signed [SAMPLE_W-1:0] sz);
    if (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(negedge clk); while (idle_en && $urandom_range(99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    action   <= act;
    sample_x <= sx;
    sample_y <= sy;
    sample_z <= sz;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_waiting != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [DEV_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DEV_W-1:0] pick_limit();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return LIMIT_RESET;
      3: return DEV_W'({$urandom, $urandom});
      default: return DEV_W'($urandom_range(12000000));
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sample_for(input run_kind_t kind, input int k,
                                                             input int bias, input int spread,
                                                             input bit high_first);
    int v;
    if (k < WARMUP_SAMPLES || kind == RUN_WILD) return SAMPLE_W'($urandom);
    case (kind)
      RUN_STILL: v = bias;
      // mean run at one rail, check run at the other
      RUN_SPAN:  v = ((k < WARMUP_SAMPLES + MEAN_SAMPLES) == high_first) ? int'(S_MAX) : int'(S_MIN);
      default:   v = bias + int'($urandom_range(2 * spread)) - spread;
    endcase
    if (v > int'(S_MAX)) v = int'(S_MAX);
    if (v < int'(S_MIN)) v = int'(S_MIN);
    return SAMPLE_W'(v);
  endfunction

  task automatic run_calibration(input run_kind_t kind, input int count, input bit restart_first,
                                 input bit allow_cfg);
    int                         bias [AXES];
    int                         spread;
    bit                         high_first;
    logic signed [SAMPLE_W-1:0] smp [AXES];
    for (int a = 0; a < AXES; a++) bias[a] = int'(S_MIN) + int'($urandom_range(65535));
    spread     = (kind == RUN_QUIET) ? $urandom_range(400) : 400 + $urandom_range(6000);
    high_first = $urandom_range(1);
    if (restart_first) send_req(ACT_RESTART, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                                SAMPLE_W'($urandom));
    for (int k = 0; k < count; k++) begin
      // limit change between mean and check phases
      if (allow_cfg && k == WARMUP_SAMPLES + MEAN_SAMPLES && $urandom_range(5) == 0) begin
        drain_results();
        write_limit(pick_limit());
      end
      for (int a = 0; a < AXES; a++) smp[a] = sample_for(kind, k, bias[a], spread, high_first);
      send_req(ACT_SAMPLE, smp[0], smp[1], smp[2]);
    end
  endtask

  initial begin
    run_kind_t kind;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_req(ACT_SAMPLE, S_MAX, S_MIN, 16'sh0000);
    send_req(ACT_SAMPLE, S_MIN, S_MAX, -16'sd1);
    send_req(ACT_SAMPLE, 16'sh0000, 16'sh0000, 16'sh0000);
    send_req(ACT_SAMPLE, 16'sh5555, 16'shAAAA, 16'sh0001);
    send_req(ACT_RESTART, S_MAX, S_MAX, S_MAX);
    send_req(ACT_RESTART, S_MIN, S_MIN, S_MIN);
    send_req(ACT_SAMPLE, 16'shAAAA, 16'sh5555, S_MIN);
    send_req(ACT_SAMPLE, 16'sh0001, -16'sd1, S_MAX);
    send_req(ACT_RESTART, 16'sh0000, 16'sh0000, 16'sh0000);

    run_calibration(RUN_STILL, RUN_SAMPLES + 2, 1'b1, 1'b0);
    drain_results();
    write_limit('0);
    run_calibration(RUN_STILL, RUN_SAMPLES, 1'b1, 1'b0);
    run_calibration(RUN_QUIET, RUN_SAMPLES, 1'b1, 1'b0);
    drain_results();
    write_limit('1);

    // back-to-back runs against a held receiver
    idle_en    <= 1'b0;
    hold_asked <= hold_asked + 1;
    run_calibration(RUN_SPAN, RUN_SAMPLES, 1'b1, 1'b0);
    run_calibration(RUN_WILD, RUN_SAMPLES, 1'b1, 1'b0);
    run_calibration(RUN_NOISY, RUN_SAMPLES, 1'b1, 1'b0);
    idle_en <= 1'b1;
    drain_results();
    write_limit(LIMIT_RESET);

    while (results_predicted < MIN_RESULTS || requests_sent < MIN_REQUESTS) begin
      if ($urandom_range(4) == 0) begin
        drain_results();
        write_limit(pick_limit());
      end
      case ($urandom_range(9))
        0:          kind = RUN_STILL;
        1, 2, 3, 4: kind = RUN_QUIET;
        5, 6, 7:    kind = RUN_NOISY;
        8:          kind = RUN_WILD;
        default:    kind = RUN_SPAN;
      endcase
      if ($urandom_range(99) < 80)
        run_calibration(kind, RUN_SAMPLES + $urandom_range(3), 1'b1, 1'b1);
      else
        run_calibration(kind, $urandom_range(RUN_SAMPLES - 1), $urandom_range(1), 1'b1);
    end

    drain_results();
    if (fail_count == 0 && results_waiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
